### rtl/core/scc_pkg.sv
// Shared widths, codes and reset values of the supercapacitor charge controller.
package scc_pkg;

	localparam int CODE_W     = 12;
	localparam int WORD_W     = 2 * CODE_W;
	localparam int SUM_W      = 18;
	localparam int NUM_W      = 22;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 22;

	typedef enum logic [MODE_W-1:0] {
		MODE_STOP    = 2'd0,
		MODE_PREPARE = 2'd1,
		MODE_RELEASE = 2'd2
	} mode_t;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_START     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CEILING   = 3'd4;

	localparam logic [CODE_W-1:0] RST_START     = 12'd1128;
	localparam logic [CODE_W-1:0] RST_STOP      = 12'd1016;
	localparam logic [CODE_W-1:0] RST_RELEASE   = 12'd1692;
	localparam logic [NUM_W-1:0]  RST_NUMERATOR = 22'd2127800;
	localparam logic [CODE_W-1:0] RST_CEILING   = 12'd2481;

endpackage

### rtl/core/scc_if.sv
// Request and result channel interfaces of the supercapacitor charge controller.
interface scc_item_if;
	logic                       valid;
	logic                       ready;
	logic                       op;
	logic [scc_pkg::CODE_W-1:0] supply_code;
	logic [scc_pkg::CODE_W-1:0] cap_code;
	logic                       robot_stopped;
	logic                       hp_depleted;
	logic                       disable_input;

	modport source (
		output valid, op, supply_code, cap_code, robot_stopped, hp_depleted, disable_input,
		input  ready
	);
	modport sink (
		input  valid, op, supply_code, cap_code, robot_stopped, hp_depleted, disable_input,
		output ready
	);
endinterface

interface scc_result_if;
	logic                       valid;
	logic                       ready;
	logic [scc_pkg::MODE_W-1:0] mode;
	logic [scc_pkg::CODE_W-1:0] drive_code;

	modport source (
		output valid, mode, drive_code,
		input  ready
	);
	modport sink (
		input  valid, mode, drive_code,
		output ready
	);
endinterface

### rtl/core/supercap_charge_controller.sv
// Top level of the supercapacitor charge controller: sample window, state control, drive divide.
//
// Usage:
//   item (valid/ready) carries one request: op sample pushes a supply/capacitor ADC code pair
//   into a sliding window of WINDOW entries; op tick averages both windows, steps the
//   stop/prepare/release controller and returns one result (mode, drive_code).
//   Sample requests give no result. Write registers through cfg_we/cfg_index/cfg_data
//   only while the block is idle, as the block does not enforce it; unknown indexes are ignored.
// Sequence:
//   A sample passes through ST_SAMPLE. A tick runs ST_AVG_S, ST_AVG_C, ST_CTRL and ST_FIN when
//   no drive divide is needed, and ST_DIV and ST_CLAMP before ST_FIN when it is: the 22-bit
//   drive quotient comes from one restoring divider that retires one quotient bit per cycle.
//   Both averages share one constant-reciprocal multiplier. item.ready is high only while idle.
// Reset:
//   arst_n clears the window (per-entry valid bits, an empty entry reads as zero), the sums,
//   the write slot, the controller (stop) and the registers to their defaults. No sweep.
// Stall:
//   A result waits in the output register; samples are still accepted meanwhile. A tick that
//   finishes while the previous result is still held waits until that one is taken.
module supercap_charge_controller #(
	parameter int WINDOW = 50
) (
	input  logic                           clk,
	input  logic                           arst_n,
	scc_item_if.sink                       item,
	scc_result_if.source                   result,
	input  logic                           cfg_we,
	input  logic [scc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [scc_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CODE_W  = scc_pkg::CODE_W;
	localparam int SUM_W   = scc_pkg::SUM_W;
	localparam int NUM_W   = scc_pkg::NUM_W;
	localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SHIFT   = SUM_W + $clog2(WINDOW);
	localparam longint unsigned RECIP = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;
	localparam int RECIP_W = SHIFT + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam int CNT_W   = $clog2(NUM_W);

	localparam logic [RECIP_W-1:0] RECIP_C   = RECIP_W'(RECIP);
	localparam logic [IDX_W-1:0]   LAST_SLOT = IDX_W'(WINDOW - 1);
	localparam logic [CNT_W-1:0]   LAST_STEP = CNT_W'(NUM_W - 1);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_SAMPLE = 8'b0000_0010,
		ST_AVG_S  = 8'b0000_0100,
		ST_AVG_C  = 8'b0000_1000,
		ST_CTRL   = 8'b0001_0000,
		ST_DIV    = 8'b0010_0000,
		ST_CLAMP  = 8'b0100_0000,
		ST_FIN    = 8'b1000_0000
	} seq_t;

	seq_t                 state_q;
	logic [CODE_W-1:0]    start_q, stop_q, release_q, ceil_q;
	logic [NUM_W-1:0]     numer_q;

	logic [IDX_W-1:0]     slot_q;
	logic [WINDOW-1:0]    valid_q;
	logic [SUM_W-1:0]     supply_sum_q, cap_sum_q;
	scc_pkg::mode_t       mode_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 res_valid_q;

	logic [CODE_W-1:0]    supply_q, cap_q;
	logic                 force_stop_q, disable_q;
	logic [PROD_W-1:0]    prod_q;
	logic [CODE_W-1:0]    supply_avg_q, divisor_q, rem_q, drive_q, res_drive_q;
	logic [NUM_W-1:0]     quo_q;
	scc_pkg::mode_t       res_mode_q;

	logic                        accept;
	logic                        out_free;
	logic [scc_pkg::WORD_W-1:0]  ram_rdata, old_word;
	logic [CODE_W-1:0]           cap_avg;
	scc_pkg::mode_t              next_mode;
	logic                        drive_en;
	logic [CODE_W:0]             shifted;
	logic [CODE_W+1:0]           diff;
	logic                        fits;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign out_free   = !res_valid_q || result.ready;

	assign result.valid      = res_valid_q;
	assign result.mode       = res_mode_q;
	assign result.drive_code = res_drive_q;

	scc_ram #(
		.WIDTH (scc_pkg::WORD_W),
		.DEPTH (WINDOW)
	) u_window (
		.clk   (clk),
		.we    (state_q == ST_SAMPLE),
		.waddr (slot_q),
		.wdata ({cap_q, supply_q}),
		.raddr (slot_q),
		.rdata (ram_rdata)
	);

	assign old_word = valid_q[slot_q] ? ram_rdata : '0;
	assign cap_avg  = prod_q[SHIFT +: CODE_W];

	always_comb begin
		next_mode = mode_q;
		if (force_stop_q) begin
			next_mode = scc_pkg::MODE_STOP;
		end else begin
			case (mode_q)
				scc_pkg::MODE_PREPARE: begin
					if (supply_avg_q < stop_q) begin
						next_mode = scc_pkg::MODE_STOP;
					end else if (cap_avg > release_q) begin
						next_mode = scc_pkg::MODE_RELEASE;
					end
				end
				scc_pkg::MODE_RELEASE: begin
					if (supply_avg_q < stop_q) begin
						next_mode = scc_pkg::MODE_STOP;
					end
				end
				default: begin
					next_mode = (supply_avg_q > start_q) ? scc_pkg::MODE_PREPARE
						: scc_pkg::MODE_STOP;
				end
			endcase
		end
	end

	assign drive_en = (next_mode == scc_pkg::MODE_PREPARE)
		|| ((next_mode == scc_pkg::MODE_RELEASE) && !disable_q);

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, divisor_q};
	assign fits    = !diff[CODE_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= scc_pkg::RST_START;
			stop_q    <= scc_pkg::RST_STOP;
			release_q <= scc_pkg::RST_RELEASE;
			numer_q   <= scc_pkg::RST_NUMERATOR;
			ceil_q    <= scc_pkg::RST_CEILING;
		end else if (cfg_we) begin
			case (cfg_index)
				scc_pkg::CFG_START:     start_q   <= cfg_data[CODE_W-1:0];
				scc_pkg::CFG_STOP:      stop_q    <= cfg_data[CODE_W-1:0];
				scc_pkg::CFG_RELEASE:   release_q <= cfg_data[CODE_W-1:0];
				scc_pkg::CFG_NUMERATOR: numer_q   <= cfg_data[NUM_W-1:0];
				scc_pkg::CFG_CEILING:   ceil_q    <= cfg_data[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			slot_q       <= '0;
			valid_q      <= '0;
			supply_sum_q <= '0;
			cap_sum_q    <= '0;
			mode_q       <= scc_pkg::MODE_STOP;
			cnt_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (item.op == scc_pkg::OP_SAMPLE) ? ST_SAMPLE : ST_AVG_S;
					end
				end
				ST_SAMPLE: begin
					supply_sum_q    <= supply_sum_q - SUM_W'(old_word[CODE_W-1:0])
						+ SUM_W'(supply_q);
					cap_sum_q       <= cap_sum_q - SUM_W'(old_word[2*CODE_W-1:CODE_W])
						+ SUM_W'(cap_q);
					valid_q[slot_q] <= 1'b1;
					slot_q          <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
					state_q         <= ST_IDLE;
				end
				ST_AVG_S: state_q <= ST_AVG_C;
				ST_AVG_C: state_q <= ST_CTRL;
				ST_CTRL: begin
					mode_q <= next_mode;
					cnt_q  <= '0;
					state_q <= (drive_en && (cap_avg != '0)) ? ST_DIV : ST_FIN;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_STEP) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			supply_q     <= item.supply_code;
			cap_q        <= item.cap_code;
			force_stop_q <= item.robot_stopped || item.hp_depleted;
			disable_q    <= item.disable_input;
		end
		case (state_q)
			ST_AVG_S: begin
				prod_q <= PROD_W'(supply_sum_q) * PROD_W'(RECIP_C);
			end
			ST_AVG_C: begin
				supply_avg_q <= prod_q[SHIFT +: CODE_W];
				prod_q       <= PROD_W'(cap_sum_q) * PROD_W'(RECIP_C);
			end
			ST_CTRL: begin
				divisor_q <= cap_avg;
				rem_q     <= '0;
				quo_q     <= numer_q;
				drive_q   <= drive_en ? ceil_q : '0;
			end
			ST_DIV: begin
				rem_q <= fits ? diff[CODE_W-1:0] : shifted[CODE_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], fits};
			end
			ST_CLAMP: begin
				drive_q <= (quo_q > NUM_W'(ceil_q)) ? ceil_q : quo_q[CODE_W-1:0];
			end
			ST_FIN: begin
				if (out_free) begin
					res_mode_q  <= mode_q;
					res_drive_q <= drive_q;
				end
			end
			default: ;
		endcase
	end

endmodule

### rtl/core/scc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 50,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/scc_checker.sv
// Port-level assertions of the supercapacitor charge controller and their bind.
module scc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       item_valid,
	input logic                       item_ready,
	input logic                       result_valid,
	input logic                       result_ready,
	input logic [scc_pkg::MODE_W-1:0] result_mode,
	input logic [scc_pkg::CODE_W-1:0] result_drive
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_mode)
			&& $stable(result_drive))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("request taken while previous one still in work");

	a_stop_no_drive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_mode == scc_pkg::MODE_STOP) |-> (result_drive == '0))
		else $error("nonzero drive in stop mode");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!item_ready))
		else $error("result appeared without a tick in work");

endmodule

bind supercap_charge_controller scc_checker u_scc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_mode  (result.mode),
	.result_drive (result.drive_code)
);

### bench/supercap_charge_controller_tb.sv
// Self-checking bench for the supercapacitor charge controller against a setpoint predictor.
`timescale 1ns / 100ps

module supercap_charge_controller_tb;

	localparam int CODE_W     = scc_pkg::CODE_W;
	localparam int WORD_W     = scc_pkg::WORD_W;
	localparam int SUM_W      = scc_pkg::SUM_W;
	localparam int NUM_W      = scc_pkg::NUM_W;
	localparam int MODE_W     = scc_pkg::MODE_W;
	localparam int CFG_IDX_W  = scc_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = scc_pkg::CFG_DATA_W;

	localparam int WINDOW      = 50;
	localparam int HALF_PERIOD = 10;
	localparam int NPHASE      = 8;
	localparam int PHASE_ITEMS = 48;
	localparam int LONG_HOLD   = 300;
	localparam int SETTLE      = 40;
	localparam int STALL_LIMIT = 2000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam logic [CFG_DATA_W-1:0] DATA_MAX  = 22'h3FFFFF;

	typedef struct {
		scc_pkg::mode_t    mode;
		logic [CODE_W-1:0] drive;
	} setpoint_t;

	class setpoint_tracker;
		logic [CODE_W-1:0] start_lvl;
		logic [CODE_W-1:0] stop_lvl;
		logic [CODE_W-1:0] release_lvl;
		logic [NUM_W-1:0]  numerator;
		logic [CODE_W-1:0] ceiling;
		logic [WORD_W-1:0] window [WINDOW];
		int unsigned       slot;
		logic [SUM_W-1:0]  supply_sum;
		logic [SUM_W-1:0]  cap_sum;
		scc_pkg::mode_t    state;
		setpoint_t         pending [$];
		int                errors;

		function new();
			foreach (window[i]) window[i] = '0;
			slot        = 0;
			supply_sum  = '0;
			cap_sum     = '0;
			state       = scc_pkg::MODE_STOP;
			start_lvl   = scc_pkg::RST_START;
			stop_lvl    = scc_pkg::RST_STOP;
			release_lvl = scc_pkg::RST_RELEASE;
			numerator   = scc_pkg::RST_NUMERATOR;
			ceiling     = scc_pkg::RST_CEILING;
			errors      = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				scc_pkg::CFG_START:     start_lvl   = data[CODE_W-1:0];
				scc_pkg::CFG_STOP:      stop_lvl    = data[CODE_W-1:0];
				scc_pkg::CFG_RELEASE:   release_lvl = data[CODE_W-1:0];
				scc_pkg::CFG_NUMERATOR: numerator   = data[NUM_W-1:0];
				scc_pkg::CFG_CEILING:   ceiling     = data[CODE_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [CODE_W-1:0] drive_for(logic [SUM_W-1:0] cap_avg);
			logic [NUM_W-1:0] q;
			if (cap_avg == 0)
				return ceiling;
			q = numerator / cap_avg;
			return (q < ceiling) ? q[CODE_W-1:0] : ceiling;
		endfunction

		function void note_request(logic op, logic [CODE_W-1:0] supply,
				logic [CODE_W-1:0] cap, logic stopped, logic depleted, logic disabled);
			logic [WORD_W-1:0] old;
			logic [SUM_W-1:0]  supply_avg;
			logic [SUM_W-1:0]  cap_avg;
			setpoint_t         sp;
			if (op == scc_pkg::OP_SAMPLE) begin
				old          = window[slot];
				supply_sum   = supply_sum - old[CODE_W-1:0] + supply;
				cap_sum      = cap_sum - old[WORD_W-1:CODE_W] + cap;
				window[slot] = {cap, supply};
				slot         = (slot == WINDOW - 1) ? 0 : slot + 1;
				return;
			end
			supply_avg = supply_sum / WINDOW;
			cap_avg    = cap_sum / WINDOW;
			if (stopped || depleted)
				state = scc_pkg::MODE_STOP;
			else
				case (state)
					scc_pkg::MODE_PREPARE: begin
						if (supply_avg < stop_lvl)
							state = scc_pkg::MODE_STOP;
						else if (cap_avg > release_lvl)
							state = scc_pkg::MODE_RELEASE;
					end
					scc_pkg::MODE_RELEASE: begin
						if (supply_avg < stop_lvl)
							state = scc_pkg::MODE_STOP;
					end
					default: state = (supply_avg > start_lvl) ? scc_pkg::MODE_PREPARE
						: scc_pkg::MODE_STOP;
				endcase
			sp.mode = state;
			if (state == scc_pkg::MODE_PREPARE
					|| (state == scc_pkg::MODE_RELEASE && !disabled))
				sp.drive = drive_for(cap_avg);
			else
				sp.drive = '0;
			pending.push_back(sp);
		endfunction

		function void check_setpoint(logic [MODE_W-1:0] mode, logic [CODE_W-1:0] drive);
			setpoint_t sp;
			if (pending.size() == 0) begin
				$error("unexpected result: mode %0d, drive_code %0d", mode, drive);
				errors++;
				return;
			end
			sp = pending.pop_front();
			if (mode !== sp.mode) begin
				$error("mode: expected %0d, got %0d", sp.mode, mode);
				errors++;
			end
			if (drive !== sp.drive) begin
				$error("drive_code: expected %0d, got %0d", sp.drive, drive);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	scc_item_if   item_ch ();
	scc_result_if result_ch ();

	setpoint_tracker tracker;
	int              accepted_items;
	int              idle_cycles;
	int              stall_left;
	bit              steady;
	bit              hold_results_request;

	supercap_charge_controller #(
		.WINDOW(WINDOW)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_ch),
		.result   (result_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CODE_W-1:0] clamp_code(int v);
		if (v < 0)
			return '0;
		if (v > 4095)
			return '1;
		return v[CODE_W-1:0];
	endfunction

	function automatic logic [CODE_W-1:0] near_level(logic [CODE_W-1:0] thr);
		int v;
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 4095);
			1: return $urandom_range(0, 1) ? '1 : '0;
			default: begin
				v = $urandom_range(0, 240);
				v = v - 120 + int'(thr);
				return clamp_code(v);
			end
		endcase
	endfunction

	function automatic logic [CODE_W-1:0] jitter(logic [CODE_W-1:0] base);
		int v;
		v = $urandom_range(0, 30);
		return clamp_code(int'(base) + v - 15);
	endfunction

	task automatic send_request(input logic op, input logic [CODE_W-1:0] supply,
			input logic [CODE_W-1:0] cap, input logic stopped, input logic depleted,
			input logic disabled);
		int gap;
		item_ch.valid         <= 1'b1;
		item_ch.op            <= op;
		item_ch.supply_code   <= supply;
		item_ch.cap_code      <= cap;
		item_ch.robot_stopped <= stopped;
		item_ch.hp_depleted   <= depleted;
		item_ch.disable_input <= disabled;
		do
			@(posedge clk);
		while (!item_ch.ready);
		tracker.note_request(op, supply, cap, stopped, depleted, disabled);
		accepted_items++;
		@(negedge clk);
		gap = steady ? 0 : pause_len();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_sample(input logic [CODE_W-1:0] supply, input logic [CODE_W-1:0] cap);
		send_request(scc_pkg::OP_SAMPLE, supply, cap, $urandom_range(0, 1),
			$urandom_range(0, 1), $urandom_range(0, 1));
	endtask

	task automatic send_tick(input logic stopped, input logic depleted, input logic disabled);
		send_request(scc_pkg::OP_TICK, $urandom_range(0, 4095), $urandom_range(0, 4095),
			stopped, depleted, disabled);
	endtask

	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		while (tracker.pending.size() > 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic program_regs(input logic [CFG_DATA_W-1:0] start_v,
			input logic [CFG_DATA_W-1:0] stop_v, input logic [CFG_DATA_W-1:0] release_v,
			input logic [CFG_DATA_W-1:0] num_v, input logic [CFG_DATA_W-1:0] ceil_v);
		logic [CFG_IDX_W-1:0]  idx [6];
		logic [CFG_DATA_W-1:0] val [6];
		idx = '{scc_pkg::CFG_START, scc_pkg::CFG_STOP, scc_pkg::CFG_RELEASE,
			scc_pkg::CFG_NUMERATOR, scc_pkg::CFG_CEILING, CFG_UNUSED};
		val = '{start_v, stop_v, release_v, num_v, ceil_v, $urandom_range(0, DATA_MAX)};
		for (int i = 0; i < 6; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			tracker.set_reg(idx[i], val[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input int n_items);
		int                target;
		int                kind;
		logic [CODE_W-1:0] s_base;
		logic [CODE_W-1:0] c_base;
		target = accepted_items + n_items;
		while (accepted_items < target) begin
			kind = $urandom_range(0, 19);
			if (kind == 0) begin
				s_base = near_level(tracker.start_lvl);
				repeat (WINDOW) send_sample(jitter(s_base), '0);
				send_tick(1'b0, 1'b0, $urandom_range(0, 1));
			end else if (kind < 4) begin
				send_request($urandom_range(0, 1), $urandom_range(0, 4095),
					$urandom_range(0, 4095), $urandom_range(0, 1), $urandom_range(0, 1),
					$urandom_range(0, 1));
			end else begin
				s_base = near_level($urandom_range(0, 1) ? tracker.start_lvl : tracker.stop_lvl);
				c_base = near_level(tracker.release_lvl);
				repeat ($urandom_range(1, 20)) send_sample(jitter(s_base), jitter(c_base));
				repeat ($urandom_range(1, 2))
					send_tick($urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
						$urandom_range(0, 3) == 0);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			tracker.check_setpoint(result_ch.mode, result_ch.drive_code);
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (item_ch.valid && item_ch.ready) ||
				(result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		result_ch.ready = 1'b0;
		stall_left      = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_results_request) begin
				hold_results_request = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= 1'b1;
				stall_left = steady ? 0 : pause_len();
			end
		end
	end

	initial begin
		clk                   = 1'b0;
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = '0;
		cfg_data              = '0;
		item_ch.valid         = 1'b0;
		item_ch.op            = scc_pkg::OP_SAMPLE;
		item_ch.supply_code   = '0;
		item_ch.cap_code      = '0;
		item_ch.robot_stopped = 1'b0;
		item_ch.hp_depleted   = 1'b0;
		item_ch.disable_input = 1'b0;
		accepted_items        = 0;
		steady                = 1'b0;
		hold_results_request  = 1'b0;
		tracker               = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty window, forced stops, then climb into prepare
		send_tick(1'b0, 1'b0, 1'b0);
		send_tick(1'b1, 1'b0, 1'b1);
		send_tick(1'b0, 1'b1, 1'b0);
		send_sample('0, '1);
		repeat (14) send_sample('1, '1);
		send_tick(1'b0, 1'b0, 1'b0);
		send_tick(1'b0, 1'b0, 1'b1);
		send_tick(1'b1, 1'b0, 1'b0);
		send_tick(1'b1, 1'b1, 1'b1);
		send_tick(1'b0, 1'b0, 1'b0);

		for (int phase = 0; phase < NPHASE; phase++) begin
			wait_idle();
			steady = (phase % 3 == 2);
			case (phase)
				0: program_regs(scc_pkg::RST_START, scc_pkg::RST_STOP, scc_pkg::RST_RELEASE,
					scc_pkg::RST_NUMERATOR, scc_pkg::RST_CEILING);
				1: program_regs('0, '0, '0, '0, '0);
				2: program_regs(12'hFFF, 12'hFFF, 12'hFFF, DATA_MAX, 12'hFFF);
				3: program_regs('0, '0, '0, DATA_MAX, 12'hFFF);
				4: program_regs(12'd2000, 12'd1500, 12'd2500, $urandom_range(0, DATA_MAX),
					$urandom_range(0, 4095));
				default: program_regs($urandom_range(0, DATA_MAX), $urandom_range(0, DATA_MAX),
					$urandom_range(0, DATA_MAX), $urandom_range(0, DATA_MAX),
					$urandom_range(0, DATA_MAX));
			endcase
			if (phase == 0)
				hold_results_request = 1'b1;
			run_phase(PHASE_ITEMS);
		end
		wait_idle();

		if (tracker.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### filelist.f
rtl/core/scc_pkg.sv
rtl/core/scc_if.sv
rtl/core/scc_ram.sv
rtl/core/supercap_charge_controller.sv
rtl/core/scc_checker.sv
bench/supercap_charge_controller_tb.sv
